### hw/rtl/hsl_pkg.sv
// shared types and constants for the http status line parser
`timescale 1ns / 1ps

package hsl_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 4;
    localparam int unsigned CODE_W = 10;

    localparam int unsigned PREFIX_LEN = 5;

    localparam logic [BYTE_W-1:0] PREFIX_CHARS [PREFIX_LEN] =
        '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F};

    localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [POS_W-1:0] POS_PREFIX_LAST = 4'd4;
    localparam logic [POS_W-1:0] POS_MAJOR       = 4'd5;
    localparam logic [POS_W-1:0] POS_DOT         = 4'd6;
    localparam logic [POS_W-1:0] POS_MINOR       = 4'd7;
    localparam logic [POS_W-1:0] POS_SPACE1      = 4'd8;
    localparam logic [POS_W-1:0] POS_CODE_FIRST  = 4'd9;
    localparam logic [POS_W-1:0] POS_CODE_MID    = 4'd10;
    localparam logic [POS_W-1:0] POS_CODE_LAST   = 4'd11;
    localparam logic [POS_W-1:0] POS_SPACE2      = 4'd12;
    localparam logic [POS_W-1:0] POS_SATURATE    = 4'd13;

    // last byte must sit at this position or later for a full line
    localparam logic [POS_W-1:0] POS_MIN_LAST    = 4'd11;

    localparam logic [CODE_W-1:0] MIN_CODE = 10'd100;

    typedef struct packed {
        logic              fits;
        logic              is_code_digit;
        logic [3:0]        digit;
    } byte_check_t;

    typedef struct packed {
        logic              ok;
        logic [CODE_W-1:0] code;
    } line_result_t;

endpackage

### hw/rtl/hsl_byte_check.sv
// per-position format check and digit decode of one line byte
`timescale 1ns / 1ps

module hsl_byte_check (
    input  logic [hsl_pkg::POS_W-1:0]  pos,
    input  logic [hsl_pkg::BYTE_W-1:0] line_byte,
    output hsl_pkg::byte_check_t       check
);

    logic is_digit;
    logic fits;
    logic [hsl_pkg::BYTE_W-1:0] digit_full;

    assign is_digit   = (line_byte >= hsl_pkg::CHAR_ZERO) && (line_byte <= hsl_pkg::CHAR_NINE);
    assign digit_full = line_byte - hsl_pkg::CHAR_ZERO;

    always_comb begin
        fits = 1'b1;
        if (pos <= hsl_pkg::POS_PREFIX_LAST) begin
            fits = (line_byte == hsl_pkg::PREFIX_CHARS[pos[2:0]]);
        end else begin
            case (pos) inside
                hsl_pkg::POS_MAJOR, hsl_pkg::POS_MINOR, hsl_pkg::POS_CODE_FIRST,
                hsl_pkg::POS_CODE_MID, hsl_pkg::POS_CODE_LAST: begin
                    fits = is_digit;
                end
                hsl_pkg::POS_DOT: begin
                    fits = (line_byte == hsl_pkg::CHAR_DOT);
                end
                hsl_pkg::POS_SPACE1, hsl_pkg::POS_SPACE2: begin
                    fits = (line_byte == hsl_pkg::CHAR_SPACE);
                end
                default: begin
                    fits = 1'b1;
                end
            endcase
        end
    end

    assign check.fits          = fits;
    assign check.is_code_digit = is_digit && (pos >= hsl_pkg::POS_CODE_FIRST)
                                 && (pos <= hsl_pkg::POS_CODE_LAST);
    assign check.digit         = digit_full[3:0];

endmodule

### hw/rtl/hsl_line_state.sv
// line state: position, valid flag, code accumulator and line result
`timescale 1ns / 1ps

module hsl_line_state (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic [hsl_pkg::BYTE_W-1:0] line_byte,
    input  logic                       line_end,
    output hsl_pkg::line_result_t      result
);

    logic [hsl_pkg::POS_W-1:0]  pos_reg;
    logic [hsl_pkg::POS_W-1:0]  pos_next;
    logic                       valid_reg;
    logic                       valid_next;
    logic [hsl_pkg::CODE_W-1:0] acc_reg;
    logic [hsl_pkg::CODE_W-1:0] acc_next;
    logic [hsl_pkg::CODE_W-1:0] acc_step;

    hsl_pkg::byte_check_t check;

    hsl_byte_check u_check (
        .pos       (pos_reg),
        .line_byte (line_byte),
        .check     (check)
    );

    // acc * 10 + digit, kept to the accumulator width
    assign acc_step = (acc_reg << 3) + (acc_reg << 1)
                      + {{(hsl_pkg::CODE_W-4){1'b0}}, check.digit};

    assign valid_next = valid_reg && check.fits;
    assign acc_next   = check.is_code_digit ? acc_step : acc_reg;
    assign pos_next   = (pos_reg < hsl_pkg::POS_SATURATE) ? pos_reg + 4'd1 : pos_reg;

    assign result.ok   = valid_next && (pos_reg >= hsl_pkg::POS_MIN_LAST)
                         && (acc_next >= hsl_pkg::MIN_CODE);
    assign result.code = acc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            valid_reg <= 1'b1;
            acc_reg   <= '0;
        end else if (step) begin
            if (line_end) begin
                pos_reg   <= '0;
                valid_reg <= 1'b1;
                acc_reg   <= '0;
            end else begin
                pos_reg   <= pos_next;
                valid_reg <= valid_next;
                acc_reg   <= acc_next;
            end
        end
    end

endmodule

### hw/rtl/http_status_line_parser.sv
// http status line parser: input register, line state logic, result register
// the result of a line is written to the result register when its last byte leaves the input register
// throughput: one byte item per cycle; stalls only while a result waits in the
// result register and the held byte ends a line
// reset: synchronous active-low aresetn empties both registers and restarts the line
`timescale 1ns / 1ps

module http_status_line_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [hsl_pkg::BYTE_W-1:0]  s_line_byte,
    input  logic                        s_line_end,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_status_ok,
    output logic [hsl_pkg::CODE_W-1:0]  m_status_code,
    output logic                        m_error_kind
);

    logic                       in_valid_reg;
    logic [hsl_pkg::BYTE_W-1:0] in_byte_reg;
    logic                       in_end_reg;
    logic                       out_valid_reg;
    logic                       out_ok_reg;
    logic [hsl_pkg::CODE_W-1:0] out_code_reg;
    logic                       out_free;
    logic                       advance;

    hsl_pkg::line_result_t result;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_end_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;

    hsl_line_state u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .line_byte (in_byte_reg),
        .line_end  (in_end_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_line_byte;
            in_end_reg  <= s_line_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_end_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_end_reg) begin
            out_ok_reg   <= result.ok;
            out_code_reg <= result.ok ? result.code : '0;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status_ok   = out_ok_reg;
    assign m_status_code = out_code_reg;
    assign m_error_kind  = !out_ok_reg;

endmodule

### verif/tb.sv
// self-checking testbench for the http status line parser
`timescale 1ns / 1ps

module tb;

    typedef logic [hsl_pkg::BYTE_W-1:0] byte_t;
    typedef byte_t byte_q_t[$];

    typedef struct packed {
        logic [hsl_pkg::BYTE_W-1:0] data;
        logic                       last;
    } line_item_t;

    typedef struct packed {
        logic                       ok;
        logic [hsl_pkg::CODE_W-1:0] code;
        logic                       err;
    } status_t;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 1500;

    logic                       aclk          = 1'b0;
    logic                       aresetn       = 1'b0;
    logic                       s_valid       = 1'b0;
    logic [hsl_pkg::BYTE_W-1:0] s_line_byte   = '0;
    logic                       s_line_end    = 1'b0;
    logic                       m_ready       = 1'b0;
    logic                       s_ready;
    logic                       m_valid;
    logic                       m_status_ok;
    logic [hsl_pkg::CODE_W-1:0] m_status_code;
    logic                       m_error_kind;

    line_item_t pending_bytes[$];
    status_t    expected_status[$];

    int error_count = 0;
    int cycle_count = 0;

    // line state as the block should see it
    int unsigned                line_pos  = 0;
    logic                       line_fits = 1'b1;
    logic [hsl_pkg::CODE_W-1:0] line_code = '0;

    int         burst_left = 1;
    int         gap_left   = 0;
    line_item_t next_item;

    int stall_mode  = 0;
    int stall_timer = 0;

    http_status_line_parser dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_line_byte   (s_line_byte),
        .s_line_end    (s_line_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status_ok   (m_status_ok),
        .m_status_code (m_status_code),
        .m_error_kind  (m_error_kind)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic is_digit(byte_t b);
        return b >= hsl_pkg::CHAR_ZERO && b <= hsl_pkg::CHAR_NINE;
    endfunction

    function automatic logic char_fits(int unsigned pos, byte_t b);
        if (pos < hsl_pkg::PREFIX_LEN)
            return b == hsl_pkg::PREFIX_CHARS[pos];
        case (pos)
            hsl_pkg::POS_MAJOR, hsl_pkg::POS_MINOR, hsl_pkg::POS_CODE_FIRST,
            hsl_pkg::POS_CODE_MID, hsl_pkg::POS_CODE_LAST:
                return is_digit(b);
            hsl_pkg::POS_DOT:
                return b == hsl_pkg::CHAR_DOT;
            hsl_pkg::POS_SPACE1, hsl_pkg::POS_SPACE2:
                return b == hsl_pkg::CHAR_SPACE;
            default:
                return 1'b1;
        endcase
    endfunction

    task automatic track_byte(input byte_t b, input logic last);
        int unsigned here;
        int unsigned acc;
        status_t     st;
        here = line_pos;
        if (!char_fits(here, b))
            line_fits = 1'b0;
        if (here >= hsl_pkg::POS_CODE_FIRST && here <= hsl_pkg::POS_CODE_LAST
            && is_digit(b)) begin
            acc = line_code * 10 + (b - hsl_pkg::CHAR_ZERO);
            line_code = acc[hsl_pkg::CODE_W-1:0];
        end
        if (line_pos < hsl_pkg::POS_SATURATE)
            line_pos++;
        if (last) begin
            st.ok = line_fits && here >= hsl_pkg::POS_MIN_LAST
                    && line_code >= hsl_pkg::MIN_CODE;
            st.code = st.ok ? line_code : '0;
            st.err = !st.ok;
            expected_status.push_back(st);
            line_pos = 0;
            line_fits = 1'b1;
            line_code = '0;
        end
    endtask

    function automatic byte_q_t text_bytes(string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    function automatic byte_t rand_digit();
        byte_t ch;
        ch = byte_t'(hsl_pkg::CHAR_ZERO + $urandom_range(0, 9));
        return ch;
    endfunction

    task automatic push_line(input byte_q_t q);
        line_item_t it;
        foreach (q[i]) begin
            it.data = q[i];
            it.last = (i == q.size() - 1);
            pending_bytes.push_back(it);
        end
    endtask

    task automatic note_error(input string msg);
        if (error_count < 10)
            $display("%s", msg);
        error_count++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                track_byte(s_line_byte, s_line_end);
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0 || pending_bytes.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    s_valid <= 1'b0;
                    s_line_byte <= byte_t'($urandom_range(0, 255));
                    s_line_end <= 1'($urandom_range(0, 1));
                end else begin
                    next_item = pending_bytes.pop_front();
                    s_valid <= 1'b1;
                    s_line_byte <= next_item.data;
                    s_line_end <= next_item.last;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    note_error($sformatf("unexpected result ok=%0d code=%0d err=%0d",
                                         m_status_ok, m_status_code, m_error_kind));
                end else begin
                    if (m_status_ok !== expected_status[0].ok ||
                        m_status_code !== expected_status[0].code ||
                        m_error_kind !== expected_status[0].err)
                        note_error($sformatf(
                            "exp ok=%0d code=%0d err=%0d, got ok=%0d code=%0d err=%0d",
                            expected_status[0].ok, expected_status[0].code,
                            expected_status[0].err, m_status_ok, m_status_code,
                            m_error_kind));
                    void'(expected_status.pop_front());
                end
            end
            if (stall_timer == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_timer = $urandom_range(20, 80);
            end else begin
                stall_timer--;
            end
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (stall_timer % 3 != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        byte_q_t buf_q;
        int      random_sent;
        int      kind;
        int      len;
        int      p;
        int      n;

        push_line(text_bytes("HTTP/1.1 200"));
        push_line(text_bytes("HTTP/1.0 999 Too Long Reason"));
        push_line(text_bytes("HTTP/1.1 099"));
        push_line(text_bytes("HTTP/9.0 100"));
        push_line(text_bytes("H"));
        push_line(text_bytes("HTTP/1.1 20"));
        push_line(text_bytes("HTTP/1.1 200X"));
        push_line(text_bytes("http/1.1 200"));
        push_line(text_bytes("HTTP/:./ 2:0"));
        buf_q = text_bytes("HTTP/1.1 404 ");
        buf_q.push_back(8'hFF);
        buf_q.push_back(8'h00);
        push_line(buf_q);

        random_sent = 0;
        while (random_sent < RANDOM_BYTES) begin
            buf_q = {};
            kind = $urandom_range(0, 99);
            if (kind < 85) begin
                for (int i = 0; i < hsl_pkg::PREFIX_LEN; i++)
                    buf_q.push_back(hsl_pkg::PREFIX_CHARS[i]);
                buf_q.push_back(rand_digit());
                buf_q.push_back(hsl_pkg::CHAR_DOT);
                buf_q.push_back(rand_digit());
                buf_q.push_back(hsl_pkg::CHAR_SPACE);
                for (int i = 0; i < 3; i++)
                    buf_q.push_back(rand_digit());
                n = $urandom_range(0, 3);
                if (n > 0)
                    buf_q.push_back(hsl_pkg::CHAR_SPACE);
                if (n > 1) begin
                    len = $urandom_range(1, 16);
                    for (int i = 0; i < len; i++)
                        buf_q.push_back(byte_t'($urandom_range(32, 126)));
                end
                // broken lines: one wrong or near-miss byte, or cut short
                if (kind >= 60) begin
                    p = $urandom_range(0, (buf_q.size() > 14) ? 14 : buf_q.size() - 1);
                    case ($urandom_range(0, 2))
                        0: buf_q[p] = byte_t'($urandom_range(0, 255));
                        1: buf_q[p] = buf_q[p] + 8'd1;
                        default: buf_q[p] = buf_q[p] - 8'd1;
                    endcase
                end
                if ($urandom_range(0, 9) == 0) begin
                    len = $urandom_range(1, buf_q.size());
                    while (buf_q.size() > len)
                        void'(buf_q.pop_back());
                end
            end else begin
                len = $urandom_range(1, 20);
                for (int i = 0; i < len; i++)
                    buf_q.push_back(byte_t'($urandom_range(0, 255)));
            end
            random_sent += buf_q.size();
            push_line(buf_q);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_bytes.size() == 0 && !s_valid);
        wait (expected_status.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
